@@ rtl/assert_macros.svh @@
// Assertion macros used by the segment intersection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define SIT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sit_pkg.sv @@
// Types and constants of the segment intersection test.
package sit_pkg;

   // Default coordinate width.
   localparam int COORD_BITS_DEF = 16;

   // Result classification.
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_CROSS = 2'd1,
      KIND_TOUCH = 2'd2
   } hit_kind_type;

   // Sign of one orientation value.
   typedef struct packed {
      logic neg;
      logic zero;
   } orient_type;

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

@@ rtl/sit_if.sv @@
// Request and response channel interfaces of the segment intersection test.
interface sit_req_if #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (
      output valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      output ready
   );
endinterface

interface sit_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 hit;
   sit_pkg::hit_kind_type hit_kind;

   modport source (output valid, hit, hit_kind, input ready);
   modport sink (input valid, hit, hit_kind, output ready);
endinterface

@@ rtl/sit_orient.sv @@
// Pipelined orientation sign of point r against segment p..q.
module sit_orient #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  sit_pkg::stage_en_type        stage_en,
   input  logic signed [COORD_BITS-1:0] p_x,
   input  logic signed [COORD_BITS-1:0] p_y,
   input  logic signed [COORD_BITS-1:0] q_x,
   input  logic signed [COORD_BITS-1:0] q_y,
   input  logic signed [COORD_BITS-1:0] r_x,
   input  logic signed [COORD_BITS-1:0] r_y,
   output sit_pkg::orient_type          sign
);
   localparam int DiffBits = COORD_BITS + 1;
   localparam int ProdBits = 2 * DiffBits;
   localparam int CrossBits = ProdBits + 1;

   logic signed [DiffBits-1:0]  d1_in, d2_in, d3_in, d4_in;
   logic signed [DiffBits-1:0]  d1_ff, d2_ff, d3_ff, d4_ff;
   logic signed [ProdBits-1:0]  m1_ff, m2_ff;
   logic signed [CrossBits-1:0] cross_diff;
   sit_pkg::orient_type         sign_in, sign_ff;

   // Stage 1: coordinate differences, one bit wider than the inputs
   always_comb begin
      d1_in = DiffBits'(r_y) - DiffBits'(p_y);
      d2_in = DiffBits'(q_x) - DiffBits'(r_x);
      d3_in = DiffBits'(r_x) - DiffBits'(p_x);
      d4_in = DiffBits'(q_y) - DiffBits'(r_y);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
         d3_ff <= d3_in;
         d4_ff <= d4_in;
      end
   end

   // Stage 2: the two exact products
   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         m1_ff <= ProdBits'(d1_ff) * ProdBits'(d2_ff);
         m2_ff <= ProdBits'(d3_ff) * ProdBits'(d4_ff);
      end
   end

   // Stage 3: cross product and its sign
   always_comb begin
      cross_diff   = CrossBits'(m1_ff) - CrossBits'(m2_ff);
      sign_in.neg  = cross_diff[CrossBits-1];
      sign_in.zero = (cross_diff == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

@@ rtl/sit_box.sv @@
// Bounding-box tests of each endpoint against the other segment, delayed to stage 3.
module sit_box #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  sit_pkg::stage_en_type        stage_en,
   input  logic signed [COORD_BITS-1:0] a1_x,
   input  logic signed [COORD_BITS-1:0] a1_y,
   input  logic signed [COORD_BITS-1:0] a2_x,
   input  logic signed [COORD_BITS-1:0] a2_y,
   input  logic signed [COORD_BITS-1:0] b1_x,
   input  logic signed [COORD_BITS-1:0] b1_y,
   input  logic signed [COORD_BITS-1:0] b2_x,
   input  logic signed [COORD_BITS-1:0] b2_y,
   output logic [3:0]                   in_box
);
   logic [3:0] box_in, box1_ff, box2_ff, box3_ff;

   // p lies in box of s..e when it is not beyond both ends on either axis
   function automatic logic box_test(
      input logic signed [COORD_BITS-1:0] px, py, sx, sy, ex, ey
   );
      logic ok_x, ok_y;
      ok_x = (px >= sx || px >= ex) && (px <= sx || px <= ex);
      ok_y = (py >= sy || py >= ey) && (py <= sy || py <= ey);
      return ok_x && ok_y;
   endfunction

   always_comb begin
      box_in[0] = box_test(b1_x, b1_y, a1_x, a1_y, a2_x, a2_y);
      box_in[1] = box_test(b2_x, b2_y, a1_x, a1_y, a2_x, a2_y);
      box_in[2] = box_test(a1_x, a1_y, b1_x, b1_y, b2_x, b2_y);
      box_in[3] = box_test(a2_x, a2_y, b1_x, b1_y, b2_x, b2_y);
   end

   // Carry the flags alongside the orientation pipeline
   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         box1_ff <= box_in;
      end
      if (stage_en.s2) begin
         box2_ff <= box1_ff;
      end
      if (stage_en.s3) begin
         box3_ff <= box2_ff;
      end
   end

   assign in_box = box3_ff;

endmodule

@@ rtl/sit_classify.sv @@
// Final stage: combines orientation signs and box flags into the result word.
module sit_classify (
   input  logic                        clock,
   input  sit_pkg::stage_en_type       stage_en,
   input  sit_pkg::orient_type         o1,
   input  sit_pkg::orient_type         o2,
   input  sit_pkg::orient_type         o3,
   input  sit_pkg::orient_type         o4,
   input  logic [3:0]                  in_box,
   output logic                        hit,
   output sit_pkg::hit_kind_type       hit_kind
);
   logic                  crossing, touch;
   sit_pkg::hit_kind_type kind_in, kind_ff;
   logic                  hit_ff;

   // General crossing wins over the collinear touch cases
   always_comb begin
      crossing = (o1 != o2) && (o3 != o4);
      touch    = (o1.zero && in_box[0]) || (o2.zero && in_box[1]) ||
                 (o3.zero && in_box[2]) || (o4.zero && in_box[3]);
      if (crossing) begin
         kind_in = sit_pkg::KIND_CROSS;
      end else if (touch) begin
         kind_in = sit_pkg::KIND_TOUCH;
      end else begin
         kind_in = sit_pkg::KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         kind_ff <= kind_in;
         hit_ff  <= crossing || touch;
      end
   end

   assign hit      = hit_ff;
   assign hit_kind = kind_ff;

endmodule

@@ rtl/segment_intersection_test.sv @@
// Top level of the segment intersection test.
// Takes one segment pair per cycle, when not stalled, and returns one word per pair, in order.
// The pipeline stages are coordinate differences and bounding-box compares,
// the 2*(COORD_BITS+1)-bit products, the cross-product subtract and sign, and
// the classification register that drives the response. Each stage holds its
// word while the next one is full and stalled, and a bubble anywhere is squeezed out, so
// throughput is one pair per cycle whenever the response side is ready.
// Coordinates are COORD_BITS-bit two's complement; results are exact.
`include "assert_macros.svh"

module segment_intersection_test #(
   parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sit_req_if.sink       req,
   sit_rsp_if.source     rsp
);
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  v1_in, v2_in, v3_in, v4_in;
   logic                  rdy1, rdy2, rdy3, rdy4;
   sit_pkg::stage_en_type stage_en;
   sit_pkg::orient_type   o1, o2, o3, o4;
   logic [3:0]            in_box;

   // Per-stage ready: a stage loads when empty or when its word moves on
   always_comb begin
      rdy4 = rsp.ready || !v4_ff;
      rdy3 = rdy4 || !v3_ff;
      rdy2 = rdy3 || !v2_ff;
      rdy1 = rdy2 || !v1_ff;
      stage_en.s1 = rdy1;
      stage_en.s2 = rdy2;
      stage_en.s3 = rdy3;
      stage_en.s4 = rdy4;
      v1_in = rdy1 ? req.valid : v1_ff;
      v2_in = rdy2 ? v1_ff : v2_ff;
      v3_in = rdy3 ? v2_ff : v3_ff;
      v4_in = rdy4 ? v3_ff : v4_ff;
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   assign req.ready = rdy1;
   assign rsp.valid = v4_ff;

   // Four orientation units
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient1 (
      .clock(clock), .stage_en(stage_en),
      .p_x(req.a_start_x), .p_y(req.a_start_y), .q_x(req.a_end_x), .q_y(req.a_end_y),
      .r_x(req.b_start_x), .r_y(req.b_start_y), .sign(o1)
   );
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient2 (
      .clock(clock), .stage_en(stage_en),
      .p_x(req.a_start_x), .p_y(req.a_start_y), .q_x(req.a_end_x), .q_y(req.a_end_y),
      .r_x(req.b_end_x), .r_y(req.b_end_y), .sign(o2)
   );
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient3 (
      .clock(clock), .stage_en(stage_en),
      .p_x(req.b_start_x), .p_y(req.b_start_y), .q_x(req.b_end_x), .q_y(req.b_end_y),
      .r_x(req.a_start_x), .r_y(req.a_start_y), .sign(o3)
   );
   sit_orient #(.COORD_BITS(COORD_BITS)) u_orient4 (
      .clock(clock), .stage_en(stage_en),
      .p_x(req.b_start_x), .p_y(req.b_start_y), .q_x(req.b_end_x), .q_y(req.b_end_y),
      .r_x(req.a_end_x), .r_y(req.a_end_y), .sign(o4)
   );

   // Endpoint bounding-box flags
   sit_box #(.COORD_BITS(COORD_BITS)) u_box (
      .clock(clock), .stage_en(stage_en),
      .a1_x(req.a_start_x), .a1_y(req.a_start_y),
      .a2_x(req.a_end_x), .a2_y(req.a_end_y),
      .b1_x(req.b_start_x), .b1_y(req.b_start_y),
      .b2_x(req.b_end_x), .b2_y(req.b_end_y),
      .in_box(in_box)
   );

   // Result word
   sit_classify u_classify (
      .clock(clock), .stage_en(stage_en),
      .o1(o1), .o2(o2), .o3(o3), .o4(o4), .in_box(in_box),
      .hit(rsp.hit), .hit_kind(rsp.hit_kind)
   );

   // Checks
   `SIT_ASSERT(a_hit_matches_kind, !rsp.valid || (rsp.hit == (rsp.hit_kind != sit_pkg::KIND_NONE)), "hit disagrees with hit_kind")
   `SIT_ASSERT(a_full_stall, !(v1_ff && v2_ff && v3_ff && v4_ff && !rsp.ready) || !req.ready, "input taken while pipeline full and stalled")
   `SIT_ASSERT_NEXT(a_stage3_move, v3_ff && rdy4, v4_ff, "word lost between stage 3 and output")
   `SIT_ASSERT_NEXT(a_stage3_hold, v3_ff && !rdy4, v3_ff, "stalled stage 3 word dropped")

endmodule

@@ tb/sv/tb_segment_intersection_test.sv @@
// Testbench for the segment intersection test: directed and random segment pairs, checked in order.
`timescale 1ns / 100ps

module tb_segment_intersection_test;

   localparam int CW          = sit_pkg::COORD_BITS_DEF;
   localparam int QUIET_LIMIT = 2000;   // cycles with no handshake on either side
   localparam int TAIL_CYCLES = 10;     // pipeline is four deep

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } seg_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sit_req_if #(.COORD_BITS(CW)) req_ch ();
   sit_rsp_if                    rsp_ch ();

   sit_pkg::hit_kind_type pending_kinds[$];
   int                    fail_count   = 0;
   int                    quiet_cycles = 0;
   bit                    req_idle_on  = 1'b1;
   bit                    rsp_idle_on  = 1'b1;

   segment_intersection_test #(.COORD_BITS(CW)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   // Sign of the cross product of segment p..q against point r.
   function automatic int orient_sign(input longint px, input longint py,
                                      input longint qx, input longint qy,
                                      input longint rx, input longint ry);
      longint v;
      v = (ry - py) * (qx - rx) - (rx - px) * (qy - ry);
      if (v < 0) return -1;
      if (v > 0) return 1;
      return 0;
   endfunction

   // Point inside the closed bounding box of segment s..e.
   function automatic bit within_box(input longint px, input longint py,
                                     input longint sx, input longint sy,
                                     input longint ex, input longint ey);
      longint lox, hix, loy, hiy;
      lox = (sx < ex) ? sx : ex;
      hix = (sx < ex) ? ex : sx;
      loy = (sy < ey) ? sy : ey;
      hiy = (sy < ey) ? ey : sy;
      return (px >= lox) && (px <= hix) && (py >= loy) && (py <= hiy);
   endfunction

   function automatic sit_pkg::hit_kind_type classify_pair(input seg_pair_type p);
      longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
      int     o1, o2, o3, o4;
      ax1 = p.a_start_x;
      ay1 = p.a_start_y;
      ax2 = p.a_end_x;
      ay2 = p.a_end_y;
      bx1 = p.b_start_x;
      by1 = p.b_start_y;
      bx2 = p.b_end_x;
      by2 = p.b_end_y;
      o1 = orient_sign(ax1, ay1, ax2, ay2, bx1, by1);
      o2 = orient_sign(ax1, ay1, ax2, ay2, bx2, by2);
      o3 = orient_sign(bx1, by1, bx2, by2, ax1, ay1);
      o4 = orient_sign(bx1, by1, bx2, by2, ax2, ay2);
      // general crossing wins over any touch
      if (o1 != o2 && o3 != o4)
         return sit_pkg::KIND_CROSS;
      if ((o1 == 0 && within_box(bx1, by1, ax1, ay1, ax2, ay2)) ||
          (o2 == 0 && within_box(bx2, by2, ax1, ay1, ax2, ay2)) ||
          (o3 == 0 && within_box(ax1, ay1, bx1, by1, bx2, by2)) ||
          (o4 == 0 && within_box(ax2, ay2, bx1, by1, bx2, by2)))
         return sit_pkg::KIND_TOUCH;
      return sit_pkg::KIND_NONE;
   endfunction

   // Expected kind for every pair the block takes
   always @(posedge clock) begin : take_pairs
      seg_pair_type pair;
      if (!reset && req_ch.valid && req_ch.ready) begin
         pair.a_start_x = req_ch.a_start_x;
         pair.a_start_y = req_ch.a_start_y;
         pair.a_end_x   = req_ch.a_end_x;
         pair.a_end_y   = req_ch.a_end_y;
         pair.b_start_x = req_ch.b_start_x;
         pair.b_start_y = req_ch.b_start_y;
         pair.b_end_x   = req_ch.b_end_x;
         pair.b_end_y   = req_ch.b_end_y;
         pending_kinds.push_back(classify_pair(pair));
      end
   end

   // ---------------------------------------------------------------
   // Response check
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_words
      sit_pkg::hit_kind_type want;
      logic                  want_hit;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_kinds.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual hit=%b hit_kind=%0d",
                     $time, rsp_ch.hit, rsp_ch.hit_kind);
            fail_count++;
         end else begin
            want     = pending_kinds.pop_front();
            want_hit = (want != sit_pkg::KIND_NONE);
            if (rsp_ch.hit !== want_hit) begin
               $display("%0t: hit mismatch, expected %b, actual %b",
                        $time, want_hit, rsp_ch.hit);
               fail_count++;
            end
            if (rsp_ch.hit_kind !== want) begin
               $display("%0t: hit_kind mismatch, expected %0d, actual %0d",
                        $time, want, rsp_ch.hit_kind);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Response side: random stall, drawn after each word
   // ---------------------------------------------------------------
   function automatic int unsigned draw_gap(input bit idle_on);
      if (!idle_on || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, 14);
   endfunction

   initial begin : sink_words
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
         gap = draw_gap(rsp_idle_on);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Send one segment pair; called and returns at a falling edge.
   task automatic send_coords(input int ax1, input int ay1, input int ax2, input int ay2,
                              input int bx1, input int by1, input int bx2, input int by2);
      int unsigned gap;
      gap = draw_gap(req_idle_on);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.a_start_x <= coord_type'(ax1);
      req_ch.a_start_y <= coord_type'(ay1);
      req_ch.a_end_x   <= coord_type'(ax2);
      req_ch.a_end_y   <= coord_type'(ay2);
      req_ch.b_start_x <= coord_type'(bx1);
      req_ch.b_start_y <= coord_type'(by1);
      req_ch.b_end_x   <= coord_type'(bx2);
      req_ch.b_end_y   <= coord_type'(by2);
      req_ch.valid     <= 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   // Stop sending until every expected word has come back
   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_kinds.size() != 0);
   endtask

   task automatic pick_idling();
      req_idle_on = ($urandom_range(0, 2) != 0);
      rsp_idle_on = ($urandom_range(0, 2) != 0);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Field extremes, crossings, collinear touches, degenerate segments
   task automatic test_directed_cases();
      // all endpoints at one extreme corner
      send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_coords( 32767,  32767,  32767,  32767,  32767,  32767,  32767,  32767);
      // full-range diagonals crossing
      send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
      // full-range parallel verticals at both edges
      send_coords(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
      // full-range axes crossing
      send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
      // collinear full-range diagonal, touching at the origin
      send_coords(-32768, -32768, 0, 0, 0, 0, 32767, 32767);
      // plain X crossing
      send_coords(0, 0, 10, 10, 0, 10, 10, 0);
      // T junction: zero orientation but crossing takes precedence
      send_coords(0, 0, 10, 0, 5, 0, 5, 5);
      // shared endpoint, not collinear
      send_coords(0, 0, 5, 5, 5, 5, 10, 0);
      // collinear overlap through b start, then b end
      send_coords(0, 0, 10, 0, 5, 0, 15, 0);
      send_coords(0, 0, 10, 0, 15, 0, 5, 0);
      // A inside B: found through a start
      send_coords(3, 3, 6, 3, 0, 3, 10, 3);
      // A inside B reversed: a end
      send_coords(6, 3, 3, 3, 10, 3, 0, 3);
      // vertical collinear meeting at one point
      send_coords(2, -5, 2, 5, 2, 5, 2, 9);
      // B inside A on a slope
      send_coords(0, 0, 100, 50, 20, 10, 40, 20);
      // collinear but disjoint
      send_coords(0, 0, 1, 1, 2, 2, 3, 3);
      // parallel, offset by one
      send_coords(0, 0, 10, 0, 0, 1, 10, 1);
      // degenerate A on B, then just off B
      send_coords(3, 3, 3, 3, 0, 0, 6, 6);
      send_coords(3, 4, 3, 4, 0, 0, 6, 6);
      // degenerate B at the end of A
      send_coords(0, 0, 10, 0, 10, 0, 10, 0);
      // both degenerate: same point, different points
      send_coords(-7, 9, -7, 9, -7, 9, -7, 9);
      send_coords(-7, 9, -7, 9, 9, -7, 9, -7);
      // lines cross outside both segments
      send_coords(0, 0, 2, 2, 5, 0, 4, 1);
      // disjoint and parallel
      send_coords(0, 0, 1, 5, 3, 0, 4, 5);
   endtask

   // Uniform coordinates over the full field range
   task automatic test_random_general();
      for (int i = 0; i < 500; i++) begin
         if (i % 100 == 0)
            pick_idling();
         send_coords($urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   // Tiny grid, often at the range edges: many shared and repeated points
   task automatic test_random_grid();
      int bx, by;
      int c[8];
      for (int i = 0; i < 600; i++) begin
         if (i % 100 == 0)
            pick_idling();
         case ($urandom_range(0, 3))
            0:       bx = -32768;
            1:       bx = 32767 - 7;
            default: bx = int'($urandom_range(0, 65528)) - 32768;
         endcase
         case ($urandom_range(0, 3))
            0:       by = -32768;
            1:       by = 32767 - 7;
            default: by = int'($urandom_range(0, 65528)) - 32768;
         endcase
         for (int j = 0; j < 8; j += 2) begin
            c[j]     = bx + int'($urandom_range(0, 7));
            c[j + 1] = by + int'($urandom_range(0, 7));
         end
         send_coords(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
      end
   endtask

   // Four points on one line, sometimes nudged off it by one unit
   task automatic test_random_collinear();
      int bx, by, dx, dy;
      int k[4];
      int nudge;
      for (int i = 0; i < 500; i++) begin
         if (i % 100 == 0)
            pick_idling();
         bx = int'($urandom_range(0, 60000)) - 30000;
         by = int'($urandom_range(0, 60000)) - 30000;
         dx = int'($urandom_range(0, 80)) - 40;
         dy = int'($urandom_range(0, 80)) - 40;
         for (int j = 0; j < 4; j++)
            k[j] = int'($urandom_range(0, 12)) - 6;
         nudge = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ? -1 : 1) : 0;
         send_coords(bx + k[0] * dx, by + k[0] * dy, bx + k[1] * dx, by + k[1] * dy,
                     bx + k[2] * dx, by + k[2] * dy, bx + k[3] * dx, by + k[3] * dy + nudge);
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin : run_tests
      req_ch.valid     = 1'b0;
      req_ch.a_start_x = '0;
      req_ch.a_start_y = '0;
      req_ch.a_end_x   = '0;
      req_ch.a_end_y   = '0;
      req_ch.b_start_x = '0;
      req_ch.b_start_y = '0;
      req_ch.b_end_x   = '0;
      req_ch.b_end_y   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      hold_until_drained();
      test_random_general();
      hold_until_drained();
      test_random_grid();
      hold_until_drained();
      test_random_collinear();
      hold_until_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_if.sv
rtl/sit_orient.sv
rtl/sit_box.sv
rtl/sit_classify.sv
rtl/segment_intersection_test.sv
tb/sv/tb_segment_intersection_test.sv
